/* src/esd_pkg.sv */
// Shared types and constants for the escape sequence decoder.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package esd_pkg;

    localparam int LEN_BITS = 16;
    localparam int DLEN_W   = 16;
    localparam int QDEPTH   = 2;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_OCTAL  = 2'd3;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_X_LOW   = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    localparam logic [7:0] COLOR_RESET = 8'h1C;

    typedef logic [LEN_BITS-1:0] len_t;

    // One queued command: up to two decoded bytes and the end-of-string flag.
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       last;
    } esd_cmd_t;

    function automatic logic [DLEN_W-1:0] sat_len(input len_t c);
        logic [LEN_BITS:0] wide;
        logic [LEN_BITS:0] lim;
        wide = {1'b0, c};
        lim  = (LEN_BITS + 1)'({DLEN_W{1'b1}});
        if (wide > lim)
            return {DLEN_W{1'b1}};
        else
            return DLEN_W'(c);
    endfunction

endpackage

/* src/esd_front.sv */
// Front end of the escape sequence decoder: accepts raw bytes and turns them into commands.
// Depends on esd_pkg.
module esd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_char,
    input  logic             in_last,
    input  logic             q_ready,
    input  logic [7:0]       color_byte,
    output logic             in_ready,
    output logic             push,
    output esd_pkg::esd_cmd_t cmd
);

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       dv;
    logic [3:0] dval;
    logic       accept;

    always_comb
    begin
        dv   = 1'b0;
        dval = 4'd0;
        if (mode_reg == esd_pkg::MODE_HEX)
        begin
            if (in_char >= 8'h30 && in_char <= 8'h39)
            begin
                dv   = 1'b1;
                dval = 4'(in_char - 8'h30);
            end
            else if (in_char >= 8'h61 && in_char <= 8'h66)
            begin
                dv   = 1'b1;
                dval = 4'(in_char - 8'h57);
            end
            else if (in_char >= 8'h41 && in_char <= 8'h46)
            begin
                dv   = 1'b1;
                dval = 4'(in_char - 8'h37);
            end
        end
        else if (in_char >= 8'h30 && in_char <= 8'h37)
        begin
            dv   = 1'b1;
            dval = {1'b0, in_char[2:0]};
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        n         = 2'd0;
        b0        = 8'd0;
        b1        = 8'd0;
        unique case (mode_reg)
            esd_pkg::MODE_NORMAL:
            begin
                if (in_char == esd_pkg::CH_BSLASH)
                    mode_next = esd_pkg::MODE_ESCAPE;
                else
                begin
                    b0 = in_char;
                    n  = 2'd1;
                end
            end
            esd_pkg::MODE_ESCAPE:
            begin
                mode_next = esd_pkg::MODE_NORMAL;
                n         = 2'd1;
                b0        = in_char;
                unique case (in_char)
                    esd_pkg::CH_A:       b0 = esd_pkg::CODE_BEL;
                    esd_pkg::CH_B:       b0 = esd_pkg::CODE_BS;
                    esd_pkg::CH_C:       b0 = color_byte;
                    esd_pkg::CH_F:       b0 = esd_pkg::CODE_FF;
                    esd_pkg::CH_N:       b0 = esd_pkg::CODE_LF;
                    esd_pkg::CH_T:       b0 = esd_pkg::CODE_TAB;
                    esd_pkg::CH_R:       b0 = esd_pkg::CODE_CR;
                    esd_pkg::CH_V:       b0 = esd_pkg::CODE_VT;
                    esd_pkg::CH_QMARK:   b0 = esd_pkg::CH_QMARK;
                    esd_pkg::CH_NEWLINE: n  = 2'd0;
                    esd_pkg::CH_X_LOW, esd_pkg::CH_X_UP:
                    begin
                        n         = 2'd0;
                        mode_next = esd_pkg::MODE_HEX;
                        acc_next  = 8'd0;
                        cnt_next  = 2'd0;
                    end
                    default:
                    begin
                        if (in_char >= 8'h30 && in_char <= 8'h37)
                        begin
                            n         = 2'd0;
                            mode_next = esd_pkg::MODE_OCTAL;
                            acc_next  = {5'd0, in_char[2:0]};
                            cnt_next  = 2'd1;
                        end
                    end
                endcase
            end
            default:
            begin
                if (!dv)
                begin
                    b0        = acc_reg;
                    n         = 2'd1;
                    mode_next = esd_pkg::MODE_NORMAL;
                    if (in_char == esd_pkg::CH_BSLASH)
                        mode_next = esd_pkg::MODE_ESCAPE;
                    else
                    begin
                        b1 = in_char;
                        n  = 2'd2;
                    end
                end
                else
                begin
                    if (mode_reg == esd_pkg::MODE_HEX)
                        acc_next = {acc_reg[3:0], dval};
                    else
                        acc_next = {acc_reg[4:0], dval[2:0]};
                    cnt_next = cnt_reg + 2'd1;
                    if ((mode_reg == esd_pkg::MODE_HEX && cnt_next >= 2'd2) ||
                        (mode_reg == esd_pkg::MODE_OCTAL && cnt_next == 2'd3))
                    begin
                        b0        = acc_next;
                        n         = 2'd1;
                        mode_next = esd_pkg::MODE_NORMAL;
                    end
                end
            end
        endcase

        if (in_last)
        begin
            if (mode_next == esd_pkg::MODE_HEX || mode_next == esd_pkg::MODE_OCTAL)
            begin
                if (n == 2'd0)
                    b0 = acc_next;
                else
                    b1 = acc_next;
                n = n + 2'd1;
            end
            mode_next = esd_pkg::MODE_NORMAL;
            cnt_next  = 2'd0;
            acc_next  = 8'd0;
        end
    end

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign push     = accept && (n != 2'd0 || in_last);
    assign cmd      = '{n: n, b0: b0, b1: b1, last: in_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            cnt_reg  <= 2'd0;
            acc_reg  <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

/* src/esd_queue.sv */
// Two-entry command queue between the decoder front end and the back end.
// Depends on esd_pkg.
module esd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  esd_pkg::esd_cmd_t wr_cmd,
    input  logic              pop,
    output logic              not_full,
    output logic              not_empty,
    output esd_pkg::esd_cmd_t rd_cmd
);

    esd_pkg::esd_cmd_t mem_reg [esd_pkg::QDEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign not_full  = cnt_reg != 2'(esd_pkg::QDEPTH);
    assign not_empty = cnt_reg != 2'd0;
    assign rd_cmd    = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/esd_back.sv */
// Back end of the escape sequence decoder: emits one result per cycle while out_ready allows, and counts length.
// Depends on esd_pkg.
module esd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  esd_pkg::esd_cmd_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              is_final,
    output logic [esd_pkg::DLEN_W-1:0] out_len
);

    logic                  m_valid_reg;
    logic [7:0]            byte_reg;
    logic                  has_reg;
    logic                  final_reg;
    logic [esd_pkg::DLEN_W-1:0] len_reg;
    logic                  sub_reg;
    esd_pkg::len_t         count_reg;
    esd_pkg::len_t         count_inc;
    logic                  load;
    logic                  fire;
    logic                  bare;
    logic                  last_piece;
    logic [7:0]            sel_byte;

    assign load       = !m_valid_reg || out_ready;
    assign fire       = load && q_valid;
    assign bare       = head.n == 2'd0;
    assign last_piece = bare || head.n == 2'd1 || sub_reg;
    assign sel_byte   = sub_reg ? head.b1 : head.b0;
    assign count_inc  = (count_reg == {esd_pkg::LEN_BITS{1'b1}}) ? count_reg
                                                                 : count_reg + 1'b1;
    assign pop        = fire && last_piece;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg  <= bare ? 8'd0 : sel_byte;
            has_reg   <= !bare;
            final_reg <= head.last && last_piece;
            len_reg   <= esd_pkg::sat_len(bare ? count_reg : count_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            sub_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            m_valid_reg <= 1'b1;
            sub_reg     <= !last_piece;
            if (head.last && last_piece)
                count_reg <= '0;
            else if (!bare)
                count_reg <= count_inc;
        end
        else if (load)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign is_final  = final_reg;
    assign out_len   = len_reg;

endmodule

/* src/escape_sequence_decoder.sv */
// Top level of the escape sequence decoder: front end, command queue and back end.
// Depends on esd_pkg, esd_front, esd_queue and esd_back.
//
//  Channel   Signals                         Content
//  s_*       s_tvalid s_tready s_tdata s_tlast   raw string bytes in
//  m_*       m_tvalid m_tready m_tdata m_tuser m_tlast   decoded results out
//  cfg_*     cfg_valid cfg_ready cfg_data    backslash-c byte register
//
// One input byte is accepted per cycle while s_tready is high; results leave one per
// cycle from an output register while m_tready allows. An input byte that produces two
// results holds the back end while it emits the second, and the two-entry queue absorbs it.
// rst_n clears the decoder state, queue and length counter and sets the register to 28.
// Either side may stall independently; a full queue deasserts s_tready.
module escape_sequence_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] decoded_length
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]        color_reg;
    logic              q_ready;
    logic              q_valid;
    logic              push;
    logic              pop;
    esd_pkg::esd_cmd_t wr_cmd;
    esd_pkg::esd_cmd_t head;
    logic [7:0]        out_byte;
    logic [esd_pkg::DLEN_W-1:0] out_len;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= esd_pkg::COLOR_RESET;
        else if (cfg_valid)
            color_reg <= cfg_data;
    end

    esd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .q_ready    (q_ready),
        .color_byte (color_reg),
        .in_ready   (s_tready),
        .push       (push),
        .cmd        (wr_cmd)
    );

    esd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (wr_cmd),
        .pop       (pop),
        .not_full  (q_ready),
        .not_empty (q_valid),
        .rd_cmd    (head)
    );

    esd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .has_byte  (m_tuser),
        .is_final  (m_tlast),
        .out_len   (out_len)
    );

    assign m_tdata = {out_len, out_byte};

    a_bare_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("End marker without final flag or with nonzero byte.");

    a_byte_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:8] != 16'd0)
        else $error("Decoded byte reported with zero length.");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("Back end consumed a command from an empty queue.");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s_tready)
        else $error("Command written while the queue was full.");

endmodule
